@@ src/assert_macros.svh @@
// assertion macros shared by the scheduler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk_i edge, off while rst_ni is low
`define RMTS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("scheduler assertion failed");

// overlapping implication built on the plain form
`define RMTS_ASSERT_IMP(label, ante, cons) \
  `RMTS_ASSERT(label, (ante) |-> (cons))

// next-cycle implication built on the plain form
`define RMTS_ASSERT_NEXT(label, ante, cons) \
  `RMTS_ASSERT(label, (ante) |=> (cons))

`endif

@@ src/rmts_pkg.sv @@
// types, register codes and helpers of the rate-monotonic tick scheduler
`timescale 1ns / 1ps

package rmts_pkg;

  localparam logic [2:0] CFG_TASK_COUNT  = 3'd0;
  localparam logic [2:0] CFG_HYPERPERIOD = 3'd1;
  localparam logic [2:0] CFG_TASK0       = 3'd2;
  localparam logic [2:0] CFG_TASK3       = 3'd5;

  typedef struct packed {
    logic [2:0]  running_task;
    logic        deadline_miss;
    logic [1:0]  missed_task;
    logic        finished;
    logic [15:0] tick_time;
  } rmts_result_t;

  // a zero period behaves as 65536
  function automatic logic [16:0] eff_period(input logic [31:0] timing);
    eff_period = (timing[31:16] == 16'd0) ? 17'h10000 : {1'b0, timing[31:16]};
  endfunction

endpackage

@@ src/rmts_tick.sv @@
// one scheduler tick: priority pick, work update, release and miss check
`timescale 1ns / 1ps

module rmts_tick import rmts_pkg::*; #(
  parameter int MAX_TASKS = 4
) (
  input  logic [2:0]   task_count_i,
  input  logic [15:0]  hyperperiod_i,
  input  logic [31:0]  timing_i [MAX_TASKS],
  input  logic         restart_i,
  input  logic [15:0]  cur_time_i,
  input  logic         halted_i,
  input  logic [15:0]  rem_i [MAX_TASKS],
  input  logic [15:0]  tsr_i [MAX_TASKS],
  output logic [15:0]  cur_time_o,
  output logic         halted_o,
  output logic [15:0]  rem_o [MAX_TASKS],
  output logic [15:0]  tsr_o [MAX_TASKS],
  output rmts_result_t res_o
);

  localparam logic [2:0] NumTasks = 3'(MAX_TASKS);

  logic [2:0]  n;
  logic [2:0]  run;
  logic        found;
  logic [16:0] best;
  logic        miss;
  logic [1:0]  missed;
  logic [16:0] t;
  logic [16:0] hp;
  logic [16:0] next_time;
  logic [15:0] rem_mid [MAX_TASKS];

  assign n = (task_count_i > NumTasks) ? NumTasks : task_count_i;

  always_comb begin
    run = 3'd0;
    found = 1'b0;
    best = 17'd0;
    miss = 1'b0;
    missed = 2'd0;
    t = 17'd0;
    cur_time_o = cur_time_i;
    halted_o = halted_i;
    rem_mid = rem_i;
    rem_o = rem_i;
    tsr_o = tsr_i;
    res_o = '0;
    hp = (hyperperiod_i == 16'd0) ? 17'h10000 : {1'b0, hyperperiod_i};
    next_time = {1'b0, cur_time_i} + 17'd1;

    // shortest period wins, strict compare keeps the lowest index on ties
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (3'(i) < n && rem_i[i] != 16'd0 &&
          (!found || eff_period(timing_i[i]) < best)) begin
        found = 1'b1;
        run = 3'(i + 1);
        best = eff_period(timing_i[i]);
      end
    end
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (found && run == 3'(i + 1)) begin
        rem_mid[i] = rem_i[i] - 16'd1;
      end
    end

    // period boundaries, miss flags the lowest index
    rem_o = rem_mid;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (3'(i) < n) begin
        t = {1'b0, tsr_i[i]} + 17'd1;
        if (t >= eff_period(timing_i[i])) begin
          if (rem_mid[i] != 16'd0 && !miss) begin
            miss = 1'b1;
            missed = 2'(i);
          end
          rem_o[i] = timing_i[i][15:0];
          tsr_o[i] = 16'd0;
        end else begin
          tsr_o[i] = t[15:0];
        end
      end
    end

    if (restart_i) begin
      cur_time_o = 16'd0;
      halted_o = 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        rem_o[i] = (3'(i) < n) ? timing_i[i][15:0] : 16'd0;
        tsr_o[i] = 16'd0;
      end
    end else if (halted_i) begin
      rem_o = rem_i;
      tsr_o = tsr_i;
      res_o.finished = 1'b1;
      res_o.tick_time = cur_time_i;
    end else begin
      cur_time_o = next_time[15:0];
      halted_o = miss || (next_time >= hp);
      res_o.running_task = run;
      res_o.deadline_miss = miss;
      res_o.missed_task = missed;
      res_o.finished = halted_o;
      res_o.tick_time = cur_time_i;
    end
  end

endmodule

@@ src/rmts_skid.sv @@
// result register with a skid stage behind it
`timescale 1ns / 1ps

module rmts_skid import rmts_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  rmts_result_t data_i,
  output logic         full_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output rmts_result_t out_data_o
);

  logic         out_valid_q;
  logic         skid_valid_q;
  rmts_result_t out_q;
  rmts_result_t skid_q;
  logic         free;

  assign free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (free) begin
      if (skid_valid_q) begin
        out_valid_q <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push_i) begin
        out_q <= data_i;
      end
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

  assign full_o = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

@@ src/rate_monotonic_tick_scheduler_top.sv @@
// top level of the rate-monotonic tick scheduler
`timescale 1ns / 1ps
// result: registered, or held in the skid stage while the output stalls
// throughput: one beat per cycle while in_stall_o is low; tick logic between state and
//   result register is combinational; the skid keeps input open while a result waits
// reset: config to task_count 1, hyperperiod 1, timings 0; time and work cleared,
//   scheduler halted until the first restart beat; no clearing pass

`include "assert_macros.svh"

module rate_monotonic_tick_scheduler_top import rmts_pkg::*; #(
  parameter int MAX_TASKS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        restart_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  running_task_o,
  output logic        deadline_miss_o,
  output logic [1:0]  missed_task_o,
  output logic        finished_o,
  output logic [15:0] tick_time_o
);

  // configuration registers
  logic [2:0]  task_count_q;
  logic [15:0] hyperperiod_q;
  logic [31:0] timing_q [MAX_TASKS];

  // scheduler state
  logic [15:0] cur_time_q, cur_time_d;
  logic        halted_q, halted_d;
  logic [15:0] rem_q [MAX_TASKS];
  logic [15:0] rem_d [MAX_TASKS];
  logic [15:0] tsr_q [MAX_TASKS];
  logic [15:0] tsr_d [MAX_TASKS];

  rmts_result_t res;
  rmts_result_t out_res;
  logic         in_accept;
  logic         skid_full;

  assign in_stall_o = skid_full;
  assign in_accept = in_valid_i && !skid_full;

  // register writes, task timings land at index minus the first timing code
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q <= 3'd1;
      hyperperiod_q <= 16'd1;
      for (int i = 0; i < MAX_TASKS; i++) begin
        timing_q[i] <= 32'd0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_TASK_COUNT) begin
        task_count_q <= cfg_data_i[2:0];
      end
      if (cfg_idx_i == CFG_HYPERPERIOD) begin
        hyperperiod_q <= cfg_data_i[15:0];
      end
      for (int i = 0; i < MAX_TASKS; i++) begin
        if (cfg_idx_i >= CFG_TASK0 && cfg_idx_i <= CFG_TASK3 &&
            cfg_idx_i - CFG_TASK0 == 3'(i)) begin
          timing_q[i] <= cfg_data_i;
        end
      end
    end
  end

  // state advances once per accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_time_q <= 16'd0;
      halted_q <= 1'b1;
      for (int i = 0; i < MAX_TASKS; i++) begin
        rem_q[i] <= 16'd0;
        tsr_q[i] <= 16'd0;
      end
    end else if (in_accept) begin
      cur_time_q <= cur_time_d;
      halted_q <= halted_d;
      rem_q <= rem_d;
      tsr_q <= tsr_d;
    end
  end

  rmts_tick #(
    .MAX_TASKS(MAX_TASKS)
  ) u_tick (
    .task_count_i (task_count_q),
    .hyperperiod_i(hyperperiod_q),
    .timing_i     (timing_q),
    .restart_i    (restart_i),
    .cur_time_i   (cur_time_q),
    .halted_i     (halted_q),
    .rem_i        (rem_q),
    .tsr_i        (tsr_q),
    .cur_time_o   (cur_time_d),
    .halted_o     (halted_d),
    .rem_o        (rem_d),
    .tsr_o        (tsr_d),
    .res_o        (res)
  );

  // result register plus skid, input stalls only when both hold a beat
  rmts_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_accept),
    .data_i     (res),
    .full_o     (skid_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_res)
  );

  assign running_task_o = out_res.running_task;
  assign deadline_miss_o = out_res.deadline_miss;
  assign missed_task_o = out_res.missed_task;
  assign finished_o = out_res.finished;
  assign tick_time_o = out_res.tick_time;

  // a full skid stage means the result register is also occupied
  `RMTS_ASSERT_IMP(skid_implies_out, in_stall_o, out_valid_o)
  // a restart beat always leaves the scheduler running
  `RMTS_ASSERT_NEXT(restart_unhalts, in_accept && restart_i, !halted_q)
  // ticks while halted leave time untouched
  `RMTS_ASSERT_NEXT(halted_holds_time, in_accept && !restart_i && halted_q,
                    $stable(cur_time_q) && halted_q)
  // a reported miss always comes with the halt flag
  `RMTS_ASSERT_IMP(miss_finishes, out_valid_o && deadline_miss_o, finished_o)

endmodule
